// ===== rtl/core/tsr_pkg.sv =====
`timescale 1ns / 1ps

package tsr_pkg;

  // Command codes
  localparam logic [1:0] CMD_PASS = 2'd0;
  localparam logic [1:0] CMD_PUT  = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  // Fixed field widths
  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 16;
  localparam int unsigned TagW = 8;

  // Input word
  typedef struct packed {
    logic [1:0]      command;
    logic [SeqW-1:0] seq_number;
    logic            syn_flag;
    logic [LenW-1:0] payload_length;
    logic [TagW-1:0] buffer_tag;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic            accepted;
    logic [SeqW-1:0] out_seq;
    logic            out_syn;
    logic [LenW-1:0] out_length;
    logic [TagW-1:0] out_tag;
    logic            dropped_full;
  } out_word_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

// ===== rtl/core/tsr_mem.sv =====
`timescale 1ns / 1ps

// Entry store: one write port, one registered read port.
module tsr_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned DataW = 57
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tcp_segment_reorder_table.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                     | Handshake
// ---------+---------------------------+------------------------------------
// input    | start_i, in_word_i        | word taken when start_i & !busy_o
// result   | done_o, out_word_o        | done_o high one cycle, one per word
//
// A pass, an unknown command, an empty put or a take before start skips the scan.
// A put or take walks the table through one compare unit, one entry per cycle
// behind the registered memory read; busy_o stays high through the scan and
// the finish state, so no new word is taken until the result is written.
// Reset is asynchronous, active low; the memory is not cleared, valid bits are.
// The receiver cannot stall; busy_o is high while a scan or its finish runs.
module tcp_segment_reorder_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tsr_pkg::in_word_t   in_word_i,
  output logic                busy_o,
  output logic                done_o,
  output tsr_pkg::out_word_t  out_word_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SeqW  = tsr_pkg::SeqW;
  localparam int unsigned LenW  = tsr_pkg::LenW;
  localparam int unsigned DataW = SeqW + 1 + LenW + TAG_BITS;
  localparam logic [CntW-1:0] CntEnd = CntW'(TABLE_DEPTH);

  tsr_pkg::state_e state_q, state_d;

  // Architectural state
  logic                   started_q, started_d;
  logic [SeqW-1:0]        expected_q, expected_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic                   held_valid_q, held_valid_d;
  logic [IdxW-1:0]        held_idx_q, held_idx_d;

  // Current word and scan bookkeeping
  tsr_pkg::in_word_t      word_q, word_d;
  logic [SeqW-1:0]        key_q, key_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   chk_q, chk_d;
  logic [IdxW-1:0]        chk_idx_q, chk_idx_d;
  logic                   hit_q, hit_d;
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic [DataW-1:0]       hit_data_q, hit_data_d;
  logic                   free_q, free_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;

  // Result register
  logic                   done_q, done_d;
  tsr_pkg::out_word_t     res_q, res_d;

  // Memory port
  logic                   we;
  logic [DataW-1:0]       wdata;
  logic [DataW-1:0]       rdata;
  logic [IdxW-1:0]        raddr;

  // Fields of the entry read out and of the entry hit
  logic [SeqW-1:0]        rd_seq;
  logic                   hit_syn;
  logic [LenW-1:0]        hit_len;
  logic [TAG_BITS-1:0]    hit_tag;
  logic [SeqW-1:0]        hit_seq;

  assign rd_seq  = rdata[DataW-1 -: SeqW];
  assign hit_seq = hit_data_q[DataW-1 -: SeqW];
  assign hit_syn = hit_data_q[LenW + TAG_BITS];
  assign hit_len = hit_data_q[TAG_BITS +: LenW];
  assign hit_tag = hit_data_q[TAG_BITS-1:0];

  assign wdata = {word_q.seq_number, word_q.syn_flag, word_q.payload_length,
                  TAG_BITS'(word_q.buffer_tag)};
  assign raddr = idx_q[IdxW-1:0];

  tsr_mem #(
    .Depth (TABLE_DEPTH),
    .DataW (DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer and shared compare unit
  always_comb begin
    logic             issue;
    logic [SeqW-1:0]  eff_exp;
    state_d      = state_q;
    started_d    = started_q;
    expected_d   = expected_q;
    valid_d      = valid_q;
    held_valid_d = held_valid_q;
    held_idx_d   = held_idx_q;
    word_d       = word_q;
    key_d        = key_q;
    idx_d        = idx_q;
    chk_d        = 1'b0;
    chk_idx_d    = chk_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_data_d   = hit_data_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    done_d       = 1'b0;
    res_d        = '0;
    we           = 1'b0;
    issue        = 1'b0;
    eff_exp      = started_q ? expected_q : in_word_i.seq_number;

    case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (start_i) begin
          word_d    = in_word_i;
          idx_d     = '0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          case (in_word_i.command)
            tsr_pkg::CMD_PASS: begin
              done_d    = 1'b1;
              started_d = 1'b1;
              if (eff_exp == in_word_i.seq_number) begin
                expected_d     = eff_exp + SeqW'(in_word_i.syn_flag)
                                 + SeqW'(in_word_i.payload_length);
                res_d.accepted = 1'b1;
              end else begin
                expected_d = eff_exp;
              end
            end
            tsr_pkg::CMD_PUT: begin
              if (!in_word_i.syn_flag && in_word_i.payload_length == '0) begin
                done_d = 1'b1;
              end else begin
                key_d   = in_word_i.seq_number;
                state_d = tsr_pkg::ST_SCAN;
              end
            end
            tsr_pkg::CMD_TAKE: begin
              if (!started_q) begin
                done_d = 1'b1;
              end else begin
                key_d   = expected_q;
                state_d = tsr_pkg::ST_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      tsr_pkg::ST_SCAN: begin
        // issue a read and note the lowest free slot
        issue = (idx_q != CntEnd);
        if (issue) begin
          idx_d     = idx_q + CntW'(1);
          chk_d     = 1'b1;
          chk_idx_d = idx_q[IdxW-1:0];
          if (!valid_q[idx_q[IdxW-1:0]] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_q[IdxW-1:0];
          end
        end
        // compare the entry read last cycle
        if (chk_q && valid_q[chk_idx_q] && rd_seq == key_q && !hit_q) begin
          hit_d      = 1'b1;
          hit_idx_d  = chk_idx_q;
          hit_data_d = rdata;
        end
        if (!issue && !chk_q) begin
          state_d = tsr_pkg::ST_FINISH;
        end
      end

      tsr_pkg::ST_FINISH: begin
        state_d = tsr_pkg::ST_IDLE;
        done_d  = 1'b1;
        if (word_q.command == tsr_pkg::CMD_PUT) begin
          if (!hit_q) begin
            if (free_q) begin
              we                  = 1'b1;
              valid_d[free_idx_q] = 1'b1;
            end else begin
              res_d.dropped_full = 1'b1;
            end
          end
          if (!started_q) begin
            started_d  = 1'b1;
            expected_d = word_q.seq_number;
          end
        end else if (hit_q) begin
          // take: free the entry handed out before, unless it is this one
          if (held_valid_q && held_idx_q != hit_idx_q) begin
            valid_d[held_idx_q] = 1'b0;
          end
          expected_d       = expected_q + SeqW'(hit_syn) + SeqW'(hit_len);
          held_valid_d     = 1'b1;
          held_idx_d       = hit_idx_q;
          res_d.accepted   = 1'b1;
          res_d.out_seq    = hit_seq;
          res_d.out_syn    = hit_syn;
          res_d.out_length = hit_len;
          res_d.out_tag    = tsr_pkg::TagW'(hit_tag);
        end
      end

      default: begin
        state_d = tsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsr_pkg::ST_IDLE;
      started_q    <= 1'b0;
      expected_q   <= '0;
      valid_q      <= '0;
      held_valid_q <= 1'b0;
      held_idx_q   <= '0;
      chk_q        <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      started_q    <= started_d;
      expected_q   <= expected_d;
      valid_q      <= valid_d;
      held_valid_q <= held_valid_d;
      held_idx_q   <= held_idx_d;
      chk_q        <= chk_d;
      done_q       <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    key_q      <= key_d;
    idx_q      <= idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_data_q <= hit_data_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  assign busy_o     = (state_q != tsr_pkg::ST_IDLE);
  assign done_o     = done_q;
  assign out_word_o = res_q;

endmodule

// ===== bench/tsr_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the reorder table, keeps a shadow of its state,
// and compares every result word against the word predicted for it.
module tsr_checker #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  tsr_pkg::in_word_t  in_word_i,
  input  logic               done_i,
  input  tsr_pkg::out_word_t out_word_i,
  output int                 errors_o,
  output int                 pending_o,
  output logic [31:0]        next_seq_o
);

  localparam logic [tsr_pkg::TagW-1:0] TagMask =
    {tsr_pkg::TagW{1'b1}} >>
    ((TAG_BITS >= tsr_pkg::TagW) ? 0 : tsr_pkg::TagW - TAG_BITS);

  // shadow of the table; next_seq_o is the expected sequence number itself
  logic                     started_q;
  logic                     slot_used [TABLE_DEPTH];
  logic [tsr_pkg::SeqW-1:0] slot_seq  [TABLE_DEPTH];
  logic                     slot_syn  [TABLE_DEPTH];
  logic [tsr_pkg::LenW-1:0] slot_len  [TABLE_DEPTH];
  logic [tsr_pkg::TagW-1:0] slot_tag  [TABLE_DEPTH];
  logic                     held_q;
  int                       held_slot;

  tsr_pkg::out_word_t due_results[$];

  task automatic flag_mismatch(input string msg);
    $display("tsr_checker @%0t: %s", $time, msg);
    errors_o++;
  endtask

  function automatic int find_slot(input logic [tsr_pkg::SeqW-1:0] key);
    int hit;
    hit = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && slot_used[i] && slot_seq[i] == key) hit = i;
    end
    return hit;
  endfunction

  // Applies one command word to the shadow state, returns its result word
  function automatic tsr_pkg::out_word_t segment_result(input tsr_pkg::in_word_t w);
    tsr_pkg::out_word_t r;
    int                 hit;
    int                 free;
    r    = '0;
    free = -1;
    case (w.command)
      tsr_pkg::CMD_PASS: begin
        if (!started_q) begin
          next_seq_o = w.seq_number;
          started_q  = 1'b1;
        end
        if (next_seq_o == w.seq_number) begin
          next_seq_o = next_seq_o + 32'(w.syn_flag) + 32'(w.payload_length);
          r.accepted = 1'b1;
        end
      end
      tsr_pkg::CMD_PUT: begin
        // empty segment: no effect at all, not even on start
        if (w.syn_flag || w.payload_length != '0) begin
          if (find_slot(w.seq_number) < 0) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (free < 0 && !slot_used[i]) free = i;
            end
            if (free < 0) begin
              r.dropped_full = 1'b1;
            end else begin
              slot_used[free] = 1'b1;
              slot_seq[free]  = w.seq_number;
              slot_syn[free]  = w.syn_flag;
              slot_len[free]  = w.payload_length;
              slot_tag[free]  = w.buffer_tag & TagMask;
            end
          end
          if (!started_q) begin
            next_seq_o = w.seq_number;
            started_q  = 1'b1;
          end
        end
      end
      tsr_pkg::CMD_TAKE: begin
        hit = started_q ? find_slot(next_seq_o) : -1;
        if (hit >= 0) begin
          // free the previous take, unless wrap brought us back to it
          if (held_q && held_slot != hit) slot_used[held_slot] = 1'b0;
          next_seq_o   = next_seq_o + 32'(slot_syn[hit]) + 32'(slot_len[hit]);
          held_q       = 1'b1;
          held_slot    = hit;
          r.accepted   = 1'b1;
          r.out_seq    = slot_seq[hit];
          r.out_syn    = slot_syn[hit];
          r.out_length = slot_len[hit];
          r.out_tag    = slot_tag[hit];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // accepted words first, so a same-edge result still finds its prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tsr_pkg::out_word_t want;
    if (!rst_ni) begin
      started_q  = 1'b0;
      next_seq_o = '0;
      held_q     = 1'b0;
      held_slot  = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      due_results.delete();
      pending_o  = 0;
      errors_o   = 0;
    end else begin
      if (start_i && !busy_i) due_results.push_back(segment_result(in_word_i));
      if (done_i) begin
        if (due_results.size() == 0) begin
          flag_mismatch("result word with nothing due");
        end else begin
          want = due_results.pop_front();
          if (out_word_i.accepted !== want.accepted)
            flag_mismatch($sformatf("accepted got %b want %b",
                                    out_word_i.accepted, want.accepted));
          if (out_word_i.out_seq !== want.out_seq)
            flag_mismatch($sformatf("out_seq got %h want %h",
                                    out_word_i.out_seq, want.out_seq));
          if (out_word_i.out_syn !== want.out_syn)
            flag_mismatch($sformatf("out_syn got %b want %b",
                                    out_word_i.out_syn, want.out_syn));
          if (out_word_i.out_length !== want.out_length)
            flag_mismatch($sformatf("out_length got %h want %h",
                                    out_word_i.out_length, want.out_length));
          if (out_word_i.out_tag !== want.out_tag)
            flag_mismatch($sformatf("out_tag got %h want %h",
                                    out_word_i.out_tag, want.out_tag));
          if (out_word_i.dropped_full !== want.dropped_full)
            flag_mismatch($sformatf("dropped_full got %b want %b",
                                    out_word_i.dropped_full, want.dropped_full));
        end
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Depth    = 16;
  localparam int unsigned TagBits  = 8;
  localparam logic [1:0]  CMD_BAD  = 2'd3;    // not a command, must be ignored
  localparam int          RandomWords = 1850;
  localparam int          CycleLimit  = 1_200_000;
  localparam int          DrainCycles = 64;
  localparam logic [31:0] WrapBase    = 32'hFFFF_0000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  tsr_pkg::in_word_t  in_word_i;
  logic               busy_o;
  logic               done_o;
  tsr_pkg::out_word_t out_word_o;
  int                 errors;
  int                 pending;
  logic [31:0]        next_seq;
  int                 cycles = 0;
  int                 counted = 0;
  int                 stray_keys = 0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  tcp_segment_reorder_table #(
    .TABLE_DEPTH(Depth),
    .TAG_BITS   (TagBits)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .in_word_i (in_word_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .out_word_o(out_word_o)
  );

  tsr_checker #(
    .TABLE_DEPTH(Depth),
    .TAG_BITS   (TagBits)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .in_word_i (in_word_i),
    .done_i    (done_o),
    .out_word_i(out_word_o),
    .errors_o  (errors),
    .pending_o (pending),
    .next_seq_o(next_seq)
  );

  // hard stop if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic tsr_pkg::in_word_t make_word(input logic [1:0] cmd,
                                                  input logic [31:0] seq,
                                                  input logic syn,
                                                  input logic [15:0] len,
                                                  input logic [7:0] tag);
    tsr_pkg::in_word_t w;
    w.command        = cmd;
    w.seq_number     = seq;
    w.syn_flag       = syn;
    w.payload_length = len;
    w.buffer_tag     = tag;
    return w;
  endfunction

  // mostly short gaps, a few long ones; none at all in a burst
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 35) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // segment shape: mostly typical sizes, some SYN-only, some at the maximum
  task automatic pick_shape(output logic syn, output logic [15:0] len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)      len = 16'($urandom_range(1, 1500));
    else if (r < 75) len = '0;
    else if (r < 90) len = 16'($urandom_range(1, 64));
    else if (r < 95) len = 16'hFFFF;
    else             len = 16'($urandom);
    syn = ($urandom_range(0, 9) == 0) || (len == '0);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input tsr_pkg::in_word_t w, input int gap);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if (gap > 0) begin
      start_i   <= 1'b0;
      in_word_i <= junk[$bits(tsr_pkg::in_word_t)-1:0];
      repeat (gap) @(negedge clk_i);
    end
    start_i   <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (!(w.command == CMD_BAD ||
          (w.command == tsr_pkg::CMD_PUT && !w.syn_flag && w.payload_length == '0)))
      counted++;
  endtask

  // unknown command, empty put, stray pass or stray take
  task automatic send_noise(input bit burst);
    case ($urandom_range(0, 3))
      0: send_word(make_word(tsr_pkg::CMD_PASS, $urandom, 1'($urandom), 16'($urandom),
                             8'($urandom)), pick_gap(burst));
      1: send_word(make_word(CMD_BAD, $urandom, 1'($urandom), 16'($urandom),
                             8'($urandom)), pick_gap(burst));
      2: send_word(make_word(tsr_pkg::CMD_PUT, $urandom, 1'b0, '0, 8'($urandom)),
                   pick_gap(burst));
      default: send_word(make_word(tsr_pkg::CMD_TAKE, $urandom, 1'($urandom),
                                   16'($urandom), 8'($urandom)), pick_gap(burst));
    endcase
  endtask

  initial begin
    logic [31:0] seq;
    logic [31:0] c_seq [8];
    logic        c_syn [8];
    logic [15:0] c_len [8];
    logic [7:0]  c_tag [8];
    int          order [8];
    logic        syn;
    logic [15:0] len;
    int          k;
    int          j;
    int          t;
    int          pick;
    bit          burst;

    rst_ni    = 1'b0;
    start_i   = 1'b0;
    in_word_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // nothing has started yet: take, unknown command and empty put do nothing
    send_word(make_word(tsr_pkg::CMD_TAKE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF), 1);
    send_word(make_word(CMD_BAD, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF), 0);
    send_word(make_word(tsr_pkg::CMD_PUT, 32'hFFFF_FFFF, 1'b0, 16'h0000, 8'h00), 2);
    send_word(make_word(tsr_pkg::CMD_TAKE, '0, 1'b0, '0, 8'h00), 0);

    // first put starts the stream; taking it wraps the expected number to zero
    send_word(make_word(tsr_pkg::CMD_PUT, WrapBase, 1'b1, 16'hFFFF, 8'hFF), 1);
    send_word(make_word(tsr_pkg::CMD_TAKE, '0, 1'b0, '0, 8'h00), 3);

    // out of order pass, zero-length in-order pass, put on the held key
    send_word(make_word(tsr_pkg::CMD_PASS, 32'd5, 1'b0, 16'h0000, 8'h00), 1);
    send_word(make_word(tsr_pkg::CMD_PASS, 32'd0, 1'b0, 16'h0000, 8'h00), 0);
    send_word(make_word(tsr_pkg::CMD_PUT, WrapBase, 1'b0, 16'd7, 8'h5A), 2);

    // fill the table, then one more put that gets dropped
    for (int n = 0; n < 15; n++)
      send_word(make_word(tsr_pkg::CMD_PUT, 32'(n), 1'b0, 16'd1, 8'(n)),
                pick_gap(1'b0));
    send_word(make_word(tsr_pkg::CMD_PUT, 32'd15, 1'b1, 16'd0, 8'h00), 0);

    // drain it; the last take misses since the dropped segment is not there
    repeat (16) send_word(make_word(tsr_pkg::CMD_TAKE, '0, 1'b0, '0, 8'h00),
                          pick_gap(1'b0));
    send_word(make_word(tsr_pkg::CMD_PASS, 32'd15, 1'b1, 16'd0, 8'h00), 0);

    // random part: mostly whole runs of segments stored out of order
    counted = 0;
    while (counted < RandomWords) begin
      burst = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
        k   = $urandom_range(1, 8);
        seq = next_seq;
        for (int i = 0; i < k; i++) begin
          pick_shape(c_syn[i], c_len[i]);
          c_seq[i] = seq;
          c_tag[i] = 8'($urandom);
          seq      = seq + 32'(c_syn[i]) + 32'(c_len[i]);
          order[i] = i;
        end
        for (int i = k - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          t        = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 3) == 0) send_noise(burst);
          send_word(make_word(tsr_pkg::CMD_PUT, c_seq[order[i]], c_syn[order[i]],
                              c_len[order[i]], c_tag[order[i]]), pick_gap(burst));
        end
        // repeated key with other content is not stored
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, k - 1);
          send_word(make_word(tsr_pkg::CMD_PUT, c_seq[j], 1'b1, 16'($urandom),
                              8'($urandom)), pick_gap(burst));
        end
        // take them back in order, sometimes one take too many
        t = k + (($urandom_range(0, 2) == 0) ? 1 : 0);
        repeat (t)
          send_word(make_word(tsr_pkg::CMD_TAKE, $urandom, 1'($urandom), 16'($urandom),
                              8'($urandom)), pick_gap(burst));
      end else if (pick < 78) begin
        pick_shape(syn, len);
        if ($urandom_range(0, 3) != 0) seq = next_seq;
        else seq = next_seq + (($urandom_range(0, 1) == 0) ? 32'd1 : 32'hFFFF_FFFF);
        send_word(make_word(tsr_pkg::CMD_PASS, seq, syn, len, 8'($urandom)),
                  pick_gap(burst));
      end else if (pick < 93) begin
        send_noise(burst);
      end else if (pick < 96 && stray_keys < 6) begin
        // a few keys far off that stay in the table for good
        stray_keys++;
        send_word(make_word(tsr_pkg::CMD_PUT, $urandom, 1'($urandom),
                            16'($urandom) | 16'd1, 8'($urandom)), pick_gap(burst));
      end else begin
        send_word(make_word(tsr_pkg::CMD_TAKE, $urandom, 1'($urandom), 16'($urandom),
                            8'($urandom)), pick_gap(burst));
      end
    end

    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
